// ===== hw/rtl/wsd_pkg.sv =====
package wsd_pkg;

  localparam int unsigned LenW   = 64;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned HcntW  = 4;

  localparam logic [3:0] OpCont  = 4'd0;
  localparam logic [3:0] OpText  = 4'd1;
  localparam logic [3:0] OpBin   = 4'd2;
  localparam logic [3:0] OpClose = 4'd8;
  localparam logic [3:0] OpPing  = 4'd9;
  localparam logic [3:0] OpPong  = 4'd10;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  typedef struct packed {
    logic            kind;
    logic            status;
    logic            fin;
    logic [3:0]      opcode;
    logic            masked;
    logic [LenW-1:0] payload_length;
    logic [3:0]      header_size;
    logic [KeyW-1:0] mask_key;
    logic [7:0]      payload_byte;
    logic            last;
  } res_t;

  function automatic logic opcode_ok(input logic [3:0] op);
    logic ok;
    ok = (op == OpCont) || (op == OpText) || (op == OpBin) ||
         (op == OpClose) || (op == OpPing) || (op == OpPong);
    return ok;
  endfunction

endpackage

// ===== hw/rtl/wsd_parse.sv =====
module wsd_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  output logic          emit,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [HcntW-1:0]    hcnt_r, hcnt_nxt;
  logic [15:0]         ftb_r, ftb_nxt;
  logic [LenW-1:0]     len_r, len_nxt;
  logic [KeyW-1:0]     key_r, key_nxt;
  logic [LenW-1:0]     left_r, left_nxt;
  logic [1:0]          kpos_r, kpos_nxt;
  logic                drop_r, drop_nxt;

  logic [7:0]          b0, b1;
  logic [3:0]          ext, size;
  logic [HcntW:0]      cnt_inc;
  logic [7:0]          kb;
  logic                bad;
  logic [LenW-1:0]     plen;

  always_comb begin
    unique case (kpos_r)
      2'd0: kb = key_r[31:24];
      2'd1: kb = key_r[23:16];
      2'd2: kb = key_r[15:8];
      2'd3: kb = key_r[7:0];
      default: kb = key_r[31:24];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    ftb_nxt   = ftb_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    left_nxt  = left_r;
    kpos_nxt  = kpos_r;
    drop_nxt  = drop_r;
    emit      = 1'b0;
    res       = '0;
    b0        = '0;
    b1        = '0;
    ext       = '0;
    size      = 4'd2;
    cnt_inc   = {1'b0, hcnt_r} + {{HcntW{1'b0}}, 1'b1};
    bad       = 1'b0;
    plen      = '0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        left_nxt = left_r - {{(LenW-1){1'b0}}, 1'b1};
        kpos_nxt = kpos_r + 2'd1;
        emit     = !drop_r;
        res.kind         = KindPayload;
        res.payload_byte = data_byte ^ kb;
        res.last         = (left_nxt == '0);
        if (left_nxt == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        if (hcnt_r == '0) begin
          ftb_nxt = {data_byte, 8'h00};
          len_nxt = '0;
          key_nxt = '0;
        end else if (hcnt_r == 4'd1) begin
          ftb_nxt = {ftb_r[15:8], data_byte};
        end
        b0 = ftb_nxt[15:8];
        b1 = ftb_nxt[7:0];
        if (b1[6:0] == Len16Code) begin
          ext = 4'd2;
        end else if (b1[6:0] == Len64Code) begin
          ext = 4'd8;
        end
        size = 4'd2 + ext + (b1[7] ? 4'd4 : 4'd0);
        if (hcnt_r >= 4'd2) begin
          if (hcnt_r < 4'd2 + ext) begin
            len_nxt = {len_nxt[LenW-9:0], data_byte};
          end else begin
            key_nxt = {key_nxt[KeyW-9:0], data_byte};
          end
        end
        if (hcnt_r == '0 || cnt_inc < {1'b0, size}) begin
          hcnt_nxt = cnt_inc[HcntW-1:0];
        end else begin
          hcnt_nxt = '0;
          bad  = (b0[6:4] != 3'b000) || !opcode_ok(b0[3:0]);
          plen = (ext == 4'd0) ? {{(LenW-7){1'b0}}, b1[6:0]} : len_nxt;
          emit = 1'b1;
          res.kind           = KindHeader;
          res.status         = bad;
          res.fin            = b0[7];
          res.opcode         = b0[3:0];
          res.masked         = b1[7];
          res.payload_length = plen;
          res.header_size    = size;
          res.mask_key       = key_nxt;
          left_nxt  = plen;
          kpos_nxt  = 2'd0;
          drop_nxt  = bad;
          phase_nxt = (plen != '0) ? PH_PAYLOAD : PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      ftb_r   <= '0;
      len_r   <= '0;
      key_r   <= '0;
      left_r  <= '0;
      kpos_r  <= '0;
      drop_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      ftb_r   <= ftb_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      left_r  <= left_nxt;
      kpos_r  <= kpos_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ===== hw/rtl/wsd_out_buf.sv =====
module wsd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_pkg::res_t push_res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output wsd_pkg::res_t out_res
);
  import wsd_pkg::*;

  res_t        slot_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot_r[rptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer_top.sv =====
// websocket frame deframer, receive side
// input channel: one frame-stream byte per request on in_data_byte,
// handshake in_valid / in_stall
// output channel: one result per request, out_kind 0 for a header
// result, 1 for an unmasked payload byte with out_last on the final one
// a header result appears when the last header byte (2 to 14) arrives;
// payload bytes of an invalid frame are dropped without a result
// each result is registered in the output buffer when its input byte is taken
// throughput: one byte per cycle while in_stall is low; the parser state and
// a 64-bit length countdown update as each byte is taken, results go to a
// two-entry buffer; while the buffer is full (receiver stalling) in_stall is
// high and no byte is taken; a buffer entry is freed in the cycle after it
// is taken; reset (rst_n low, synchronous) returns the parser to the start
// of a header and empties the result buffer
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_status,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_masked,
  output logic [63:0] out_payload_length,
  output logic [3:0]  out_header_size,
  output logic [31:0] out_mask_key,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);
  import wsd_pkg::*;

  logic acc;
  logic emit;
  logic full;
  res_t res;
  res_t ores;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  wsd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .emit      (emit),
    .res       (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && emit),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (ores)
  );

  assign out_kind           = ores.kind;
  assign out_status         = ores.status;
  assign out_fin            = ores.fin;
  assign out_opcode         = ores.opcode;
  assign out_masked         = ores.masked;
  assign out_payload_length = ores.payload_length;
  assign out_header_size    = ores.header_size;
  assign out_mask_key       = ores.mask_key;
  assign out_payload_byte   = ores.payload_byte;
  assign out_last           = ores.last;

endmodule
